// ===== sv/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared constants, types and helpers of the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // Table geometry
  localparam int unsigned INDEX_BITS = 12;
  localparam int unsigned IDX_W      = INDEX_BITS;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TALLY_W    = 32;

  // 2-bit saturating counter
  localparam int unsigned CTR_W = 2;
  typedef logic [CTR_W-1:0] ctr_t;
  localparam ctr_t CTR_MAX       = ctr_t'(3);
  localparam ctr_t CTR_MIN       = ctr_t'(0);
  localparam ctr_t CTR_TAKEN_MIN = ctr_t'(2);
  localparam ctr_t CTR_RESET     = ctr_t'(2);

  // Request kinds and prediction policies
  localparam logic MODE_QUERY    = 1'b0;
  localparam logic MODE_UPDATE   = 1'b1;
  localparam logic POLICY_ALWAYS = 1'b0;
  localparam logic POLICY_GSHARE = 1'b1;
  localparam logic POLICY_RESET  = POLICY_GSHARE;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TALLY_W-1:0] tally_t;

  // Tally control from the pipeline
  typedef struct packed {
    logic upd;   // an update retires this cycle
    logic miss;  // its given prediction was wrong
  } tally_req_t;

  // Train a counter toward the outcome, saturating at both ends
  function automatic ctr_t ctr_next(input ctr_t c, input logic taken);
    ctr_t r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + ctr_t'(1);
    end else begin
      if (c != CTR_MIN) r = c - ctr_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/gshare_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare direction predictor with a table of 2-bit saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a query
//   (mode 0) or a resolved-branch update (mode 1). Every request yields one
//   result on the output channel (out_valid_o / out_stall_i): the prediction
//   from the state before the request and both running tallies.
//   A result passes the read stage and the output register before it is
//   valid. One request per cycle is sustained unless sweeping or stalled;
//   the counter table is a one-read, one-write RAM with a registered read,
//   read-modify-write over two stages with forwarding of the counter
//   written back in the same cycle as a dependent read.
//   After reset the table is swept to weakly taken, one entry per cycle,
//   with in_stall_o high until every entry is written. Config writes
//   (cfg_we_i) are taken at any time, policy resets to gshare.
//   When the receiver stalls, the result holds in the output register; one
//   more request sits in the read stage, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module gshare_branch_predictor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [gbp_pkg::ADDR_W-1:0]  branch_address_i,
  input  logic                        given_prediction_i,
  input  logic                        actual_outcome_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        predict_taken_o,
  output logic [gbp_pkg::TALLY_W-1:0] branch_total_o,
  output logic [gbp_pkg::TALLY_W-1:0] mispredict_total_o
);
  import gbp_pkg::*;

  // Control state
  logic   policy_q;
  logic   clr_busy_q;
  idx_t   clr_idx_q;
  idx_t   hist_q, hist_d;
  logic [IDX_W:0] hist_sh;

  // Read stage
  logic   s1_vld_q;
  logic   s1_upd_q;
  logic   s1_miss_q;
  logic   s1_out_q;
  idx_t   s1_idx_q;
  logic   fwd_q;
  ctr_t   fwd_val_q;

  // Output register
  logic   out_vld_q;
  logic   out_pred_q;
  tally_t out_branch_q, out_miss_q;

  logic       in_acc;
  logic       s1_adv;
  idx_t       in_idx;
  ctr_t       ram_rdata;
  ctr_t       s1_ctr;
  ctr_t       s1_ctr_new;
  logic       ram_we;
  idx_t       ram_waddr;
  ctr_t       ram_wdata;
  tally_req_t tally_req;
  tally_t     branch_nxt, miss_nxt;

  // Handshake
  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_vld_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Table index and history shift
  assign in_idx  = branch_address_i[IDX_W-1:0] ^ hist_q;
  assign hist_sh = {hist_q, actual_outcome_i};
  assign hist_d  = (in_acc && (mode_i == MODE_UPDATE)) ? hist_sh[IDX_W-1:0] : hist_q;

  // Counter read-modify-write
  assign s1_ctr     = fwd_q ? fwd_val_q : ram_rdata;
  assign s1_ctr_new = ctr_next(s1_ctr, s1_out_q);

  // Write port: clearing sweep, else write-back of a retiring update
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = CTR_RESET;
    end else begin
      ram_we    = s1_adv && s1_upd_q;
      ram_waddr = s1_idx_q;
      ram_wdata = s1_ctr_new;
    end
  end

  gbp_ram #(
    .AW (IDX_W),
    .DW (CTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  assign tally_req.upd  = s1_adv && s1_upd_q;
  assign tally_req.miss = s1_miss_q;

  gbp_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (tally_req),
    .branch_nxt_o (branch_nxt),
    .miss_nxt_o   (miss_nxt)
  );

  // Policy register, clearing sweep and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= POLICY_RESET;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      hist_q     <= '0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + idx_t'(1);
        if (clr_idx_q == '1) clr_busy_q <= 1'b0;
      end
      hist_q <= hist_d;
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  // Read stage payload; forward a write-back that hits the entry being read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_upd_q  <= (mode_i == MODE_UPDATE);
      s1_miss_q <= given_prediction_i ^ actual_outcome_i;
      s1_out_q  <= actual_outcome_i;
      s1_idx_q  <= in_idx;
      fwd_q     <= s1_adv && s1_upd_q && (s1_idx_q == in_idx);
      fwd_val_q <= s1_ctr_new;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pred_q   <= (policy_q == POLICY_ALWAYS) ? 1'b1 : (s1_ctr >= CTR_TAKEN_MIN);
      out_branch_q <= branch_nxt;
      out_miss_q   <= miss_nxt;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign predict_taken_o    = out_pred_q;
  assign branch_total_o     = out_branch_q;
  assign mispredict_total_o = out_miss_q;

endmodule

// ===== sv/gbp_ram.sv =====
// ----------------------------------------------------------------------------
// gbp_ram
// Simple dual-port synchronous RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module gbp_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 2
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gbp_tally.sv =====
// ----------------------------------------------------------------------------
// gbp_tally
// Saturating branch and mispredict counts, with look-ahead values.
// ----------------------------------------------------------------------------
module gbp_tally (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbp_pkg::tally_req_t req_i,
  output gbp_pkg::tally_t     branch_nxt_o,
  output gbp_pkg::tally_t     miss_nxt_o
);
  import gbp_pkg::*;

  tally_t branch_q, branch_d;
  tally_t miss_q, miss_d;

  // Saturating increments
  always_comb begin
    branch_d = branch_q;
    miss_d   = miss_q;
    if (req_i.upd && (branch_q != '1)) branch_d = branch_q + tally_t'(1);
    if (req_i.upd && req_i.miss && (miss_q != '1)) miss_d = miss_q + tally_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_q <= '0;
      miss_q   <= '0;
    end else begin
      branch_q <= branch_d;
      miss_q   <= miss_d;
    end
  end

  assign branch_nxt_o = branch_d;
  assign miss_nxt_o   = miss_d;

endmodule

// ===== test/gbp_checker.sv =====
// ----------------------------------------------------------------------------
// gbp_checker
// Watches both channels of the gshare predictor, keeps its own copy of the
// counter table, history, tallies and policy, and compares every result with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module gbp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        mode_i,
  input  logic [gbp_pkg::ADDR_W-1:0]  branch_address_i,
  input  logic                        given_prediction_i,
  input  logic                        actual_outcome_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        predict_taken_i,
  input  logic [gbp_pkg::TALLY_W-1:0] branch_total_i,
  input  logic [gbp_pkg::TALLY_W-1:0] mispredict_total_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import gbp_pkg::*;

  localparam int unsigned TABLE_SIZE = 1 << INDEX_BITS;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic   taken;
    tally_t branches;
    tally_t misses;
  } branch_result_t;

  // Shadow state of the predictor
  ctr_t   shadow_ctr [TABLE_SIZE];
  idx_t   shadow_hist;
  tally_t shadow_branches;
  tally_t shadow_misses;
  logic   shadow_policy;

  branch_result_t expected_results [$];
  int             mismatches;
  int             waiting;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) shadow_ctr[i] = CTR_RESET;
    shadow_hist     = '0;
    shadow_branches = '0;
    shadow_misses   = '0;
    shadow_policy   = POLICY_RESET;
    mismatches      = 0;
    waiting         = 0;
  end

  function automatic tally_t tally_bump(input tally_t v);
    return (v == '1) ? v : v + tally_t'(1);
  endfunction

  // Prediction from the state before the request, then training on updates
  function automatic branch_result_t predict_branch(input logic upd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic given,
                                                    input logic outcome);
    idx_t           idx;
    ctr_t           c;
    branch_result_t r;
    idx = idx_t'(addr) ^ shadow_hist;
    c   = shadow_ctr[idx];
    r.taken = (shadow_policy == POLICY_ALWAYS) ? 1'b1 : (c >= CTR_TAKEN_MIN);
    if (upd == MODE_UPDATE) begin
      shadow_branches = tally_bump(shadow_branches);
      if (given != outcome) shadow_misses = tally_bump(shadow_misses);
      if (outcome) begin
        if (c != CTR_MAX) c = c + ctr_t'(1);
      end else begin
        if (c != CTR_MIN) c = c - ctr_t'(1);
      end
      shadow_ctr[idx] = c;
      shadow_hist     = {shadow_hist[IDX_W-2:0], outcome};
    end
    r.branches = shadow_branches;
    r.misses   = shadow_misses;
    return r;
  endfunction

  // Results first: a request taken at this edge cannot be answered at it
  always @(posedge clk_i) begin
    branch_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) shadow_policy = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result: taken %0b branches %0d misses %0d",
                     predict_taken_i, branch_total_i, mispredict_total_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.taken !== predict_taken_i || want.branches !== branch_total_i ||
              want.misses !== mispredict_total_i) begin
            if (mismatches < REPORT_MAX)
              $display("result differs: taken %0b/%0b branches %0d/%0d misses %0d/%0d",
                       want.taken, predict_taken_i, want.branches, branch_total_i,
                       want.misses, mispredict_total_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_branch(mode_i, branch_address_i,
                                                  given_prediction_i, actual_outcome_i));
      waiting = expected_results.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the gshare predictor: directed corner requests,
// then phases of random bursts (loop branches, small working sets, noise)
// under both policies, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import gbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int PHASES         = 4;
  localparam int TAIL_CYCLES    = 10;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic [ADDR_W-1:0]  branch_address;
  logic               given_prediction;
  logic               actual_outcome;
  logic               out_valid;
  logic               out_stall;
  logic               predict_taken;
  logic [TALLY_W-1:0] branch_total;
  logic [TALLY_W-1:0] mispredict_total;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int items_sent  = 0;

  gshare_branch_predictor uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .mode_i             (mode),
    .branch_address_i   (branch_address),
    .given_prediction_i (given_prediction),
    .actual_outcome_i   (actual_outcome),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .predict_taken_o    (predict_taken),
    .branch_total_o     (branch_total),
    .mispredict_total_o (mispredict_total)
  );

  gbp_checker chk (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .mode_i             (mode),
    .branch_address_i   (branch_address),
    .given_prediction_i (given_prediction),
    .actual_outcome_i   (actual_outcome),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .predict_taken_i    (predict_taken),
    .branch_total_i     (branch_total),
    .mispredict_total_i (mispredict_total),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver stall pattern
  initial begin
    int kind;
    int run;
    out_stall = 1'b0;
    forever begin
      kind = $urandom_range(0, 3);
      run  = (kind == 3) ? $urandom_range(1, 12) : $urandom_range(5, 40);
      repeat (run) begin
        @(negedge clk);
        case (kind)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
          default: begin
            out_stall <= 1'b1;
          end
        endcase
      end
    end
  end

  // One request, held until taken
  task automatic send_request(input logic m, input logic [ADDR_W-1:0] a,
                              input logic g, input logic o);
    @(negedge clk);
    in_valid         <= 1'b1;
    mode             <= m;
    branch_address   <= a;
    given_prediction <= g;
    actual_outcome   <= o;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_policy(input logic v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One burst of back-to-back requests of a random flavor
  task automatic random_burst();
    int                scenario;
    int                n;
    int                period;
    logic              steady;
    logic              bias;
    logic              o;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] work_set [4];
    scenario = $urandom_range(0, 9);
    if (scenario < 4) begin
      // loop branch: one PC, steady or periodic exit pattern
      pc     = $urandom;
      steady = 1'($urandom_range(0, 1));
      bias   = 1'($urandom_range(0, 1));
      period = $urandom_range(2, 8);
      n      = $urandom_range(16, 48);
      for (int i = 0; i < n; i++) begin
        o = steady ? bias : ((i % period) != period - 1);
        if ($urandom_range(0, 2) != 0)
          send_request(MODE_QUERY, pc, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        send_request(MODE_UPDATE, pc, ($urandom_range(0, 3) == 0) ? ~o : o, o);
      end
    end else if (scenario < 7) begin
      // small working set of branches
      foreach (work_set[k]) work_set[k] = $urandom;
      bias = 1'($urandom_range(0, 1));
      n    = $urandom_range(8, 32);
      repeat (n) begin
        o = ($urandom_range(0, 3) == 0) ? ~bias : bias;
        send_request(1'($urandom_range(0, 1)), work_set[2'($urandom_range(0, 3))],
                     1'($urandom_range(0, 1)), o);
      end
    end else begin
      // noise
      n = $urandom_range(1, 24);
      repeat (n)
        send_request(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    end
  endtask

  // Main sequence
  initial begin
    int target;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = POLICY_RESET;
    in_valid         = 1'b0;
    mode             = MODE_QUERY;
    branch_address   = '0;
    given_prediction = 1'b0;
    actual_outcome   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // fresh table: weakly taken everywhere, address extremes
    send_request(MODE_QUERY, 32'h0000_0000, 1'b0, 1'b0);
    send_request(MODE_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // not-taken keeps history at zero, so one counter walks down and sticks at 0
    repeat (5) send_request(MODE_UPDATE, 32'h0000_0ABC, 1'b1, 1'b0);
    send_request(MODE_QUERY, 32'h0000_0ABC, 1'b0, 1'b0);
    send_request(MODE_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(MODE_UPDATE, 32'h8000_0000, 1'b0, 1'b1);
    // always-taken mode: history is now 2'b11, hit the counter stuck at zero
    write_policy(POLICY_ALWAYS);
    send_request(MODE_QUERY, 32'h0000_0ABF, 1'b0, 1'b0);
    send_request(MODE_UPDATE, 32'h0000_0ABF, 1'b1, 1'b0);
    send_request(MODE_UPDATE, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_request(MODE_UPDATE, 32'h0000_0001, 1'b0, 1'b1);
    send_request(MODE_QUERY, 32'h1234_5678, 1'b1, 1'b0);
    // back to the table: training done in always mode must show
    write_policy(POLICY_GSHARE);
    send_request(MODE_QUERY, 32'h0000_0ABF, 1'b0, 1'b1);
    send_request(MODE_QUERY, 32'h0000_0AB0, 1'b1, 1'b0);
    send_request(MODE_UPDATE, 32'h5555_5555, 1'b1, 1'b0);
    send_request(MODE_UPDATE, 32'hAAAA_AAAA, 1'b0, 1'b1);

    // random phases, policy rewritten before each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_policy(POLICY_GSHARE);
        1: write_policy(POLICY_ALWAYS);
        2: write_policy(POLICY_GSHARE);
        default: write_policy(1'($urandom_range(0, 1)));
      endcase
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        random_burst();
        pause(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gbp_pkg.sv
sv/gbp_ram.sv
sv/gbp_tally.sv
sv/gshare_branch_predictor.sv
test/gbp_checker.sv
test/tb.sv
